### rtl/plfd_pkg.sv
// Package for the preamble/length deframer: phase codes, the configuration
// bundle and the result item type shared by the deframer modules.
// Depends on nothing.
`default_nettype none

package plfd_pkg;

    // Phase codes as seen on the result stream
    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_PREAMBLE = 3'd1,
        PH_LENGTH   = 3'd2,
        PH_COLLECT  = 3'd3,
        PH_FOUND    = 3'd4,
        PH_ERROR    = 3'd5
    } phase_t;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_FIRST_SYNC  = 2'd0;
    localparam logic [1:0] REG_SECOND_SYNC = 2'd1;
    localparam logic [1:0] REG_MAX_LENGTH  = 2'd2;

    localparam logic [7:0]  FIRST_SYNC_RESET  = 8'hFC;
    localparam logic [7:0]  SECOND_SYNC_RESET = 8'hCC;
    localparam logic [15:0] MAX_LENGTH_RESET  = 16'd4096;

    typedef struct packed {
        logic [7:0]  first_sync_byte;
        logic [7:0]  second_sync_byte;
        logic [15:0] max_payload_len;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  phase_code;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        frame_end;
        logic [15:0] frame_len;
    } result_t;

endpackage

`default_nettype wire

### rtl/plfd_cfg_regs.sv
// Configuration register file of the deframer on an APB-style port.
// Depends on plfd_pkg.
`default_nettype none

module plfd_cfg_regs (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output plfd_pkg::cfg_t      cfg
);

    plfd_pkg::cfg_t cfg_reg;
    plfd_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [1:0]     reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite & pready;
    assign reg_index = paddr[3:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_index)
                plfd_pkg::REG_FIRST_SYNC:  cfg_next.first_sync_byte  = pwdata[7:0];
                plfd_pkg::REG_SECOND_SYNC: cfg_next.second_sync_byte = pwdata[7:0];
                plfd_pkg::REG_MAX_LENGTH:  cfg_next.max_payload_len  = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_sync_byte  <= plfd_pkg::FIRST_SYNC_RESET;
            cfg_reg.second_sync_byte <= plfd_pkg::SECOND_SYNC_RESET;
            cfg_reg.max_payload_len  <= plfd_pkg::MAX_LENGTH_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_index)
            plfd_pkg::REG_FIRST_SYNC:  prdata = {24'd0, cfg_reg.first_sync_byte};
            plfd_pkg::REG_SECOND_SYNC: prdata = {24'd0, cfg_reg.second_sync_byte};
            plfd_pkg::REG_MAX_LENGTH:  prdata = {16'd0, cfg_reg.max_payload_len};
            default:                   prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/plfd_core.sv
// Deframer state machine: phase, byte counter and length registers, and the
// result item formed from each accepted byte.
// Depends on plfd_pkg.
`default_nettype none

module plfd_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            byte_en,
    input  wire logic [7:0]      rx_byte,
    input  wire plfd_pkg::cfg_t  cfg,
    output plfd_pkg::result_t    result
);

    plfd_pkg::phase_t phase_reg, phase_next;
    logic [15:0]      count_reg, count_next;
    logic [15:0]      length_reg, length_next;
    logic [15:0]      count_inc;
    logic [15:0]      full_length;

    assign count_inc   = count_reg + 16'd1;
    assign full_length = {rx_byte, length_reg[7:0]};

    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        length_next = length_reg;
        result      = '0;
        case (phase_reg)
            plfd_pkg::PH_IDLE: begin
                if (rx_byte == cfg.first_sync_byte) phase_next = plfd_pkg::PH_PREAMBLE;
            end
            plfd_pkg::PH_PREAMBLE: begin
                if (rx_byte == cfg.second_sync_byte) begin
                    count_next = 16'd0;
                    phase_next = plfd_pkg::PH_LENGTH;
                end else begin
                    phase_next = plfd_pkg::PH_IDLE;
                end
            end
            plfd_pkg::PH_LENGTH: begin
                if (count_reg == 16'd0) begin
                    length_next = {length_reg[15:8], rx_byte};
                    count_next  = 16'd1;
                end else begin
                    length_next = full_length;
                    if (full_length > cfg.max_payload_len) begin
                        count_next = 16'd2;
                        phase_next = plfd_pkg::PH_ERROR;
                    end else if (full_length == 16'd0) begin
                        count_next = 16'd0;
                        phase_next = plfd_pkg::PH_IDLE;
                    end else begin
                        count_next = 16'd0;
                        phase_next = plfd_pkg::PH_COLLECT;
                    end
                end
            end
            plfd_pkg::PH_COLLECT: begin
                result.payload_valid = 1'b1;
                result.payload_byte  = rx_byte;
                count_next           = count_inc;
                if (count_inc == length_reg) begin
                    phase_next       = plfd_pkg::PH_FOUND;
                    result.frame_end = 1'b1;
                    result.frame_len = length_reg;
                end
            end
            plfd_pkg::PH_FOUND: begin
                count_next = 16'd0;
                if (rx_byte == cfg.first_sync_byte) phase_next = plfd_pkg::PH_PREAMBLE;
            end
            default: begin
                // error or unreachable code: drop the byte, clear all state
                phase_next  = plfd_pkg::PH_IDLE;
                count_next  = 16'd0;
                length_next = 16'd0;
            end
        endcase
        result.phase_code = phase_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= plfd_pkg::PH_IDLE;
            count_reg  <= 16'd0;
            length_reg <= 16'd0;
        end else if (byte_en) begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            length_reg <= length_next;
        end
    end

endmodule

`default_nettype wire

### rtl/plfd_out_skid.sv
// Result register with a skid stage so the input side keeps flowing while
// a result waits on the output. Depends on plfd_pkg.
`default_nettype none

module plfd_out_skid (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire plfd_pkg::result_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output plfd_pkg::result_t       out_data
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    plfd_pkg::result_t out_data_reg;
    plfd_pkg::result_t skid_data_reg;
    logic              in_take;

    assign in_ready = ~skid_valid_reg;
    assign in_take  = in_valid & in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            // output slot free: refill from skid first, else from input
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_take;
            end
        end else if (in_take) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready || !out_valid_reg) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_take) begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### rtl/preamble_length_deframer.sv
// Preamble/length deframer, top level: register file, state machine, output stage.
// Depends on plfd_pkg, plfd_cfg_regs, plfd_core and plfd_out_skid.
//
// Takes one received byte per slave transaction and returns exactly one result
// transaction per byte, at a sustained rate of one byte per clock while the
// master side keeps taking results. A frame is a first sync byte, a second sync
// byte straight after it, a 16-bit length low byte first, then that many payload
// bytes. Payload bytes stream out as they arrive (tuser bit 3 set) and the last
// one carries tlast with the frame length in tdata. A zero length returns to idle;
// a length above the maximum length register enters error, the next byte is
// dropped and all state clears.
// A one-byte state update sits between the input and a result register backed by
// a skid stage, so s_tready stays high unless two results wait on the master side.
// Write configuration registers only while the stream is idle; new values act on
// the next byte. Registers: 0x0 first sync byte, 0x4 second sync byte, 0x8 maximum
// frame length.
`default_nettype none

module preamble_length_deframer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // received bytes
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] payload_byte, [23:8] frame_len
    output logic             m_tlast,   // frame_end
    output logic [3:0]       m_tuser    // [2:0] phase_code, [3] payload_valid
);

    plfd_pkg::cfg_t    cfg;
    plfd_pkg::result_t core_result;
    plfd_pkg::result_t out_result;
    logic              byte_accept;

    assign byte_accept = s_tvalid & s_tready;

    plfd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // advance the state machine only on an accepted transaction
    plfd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_en (byte_accept),
        .rx_byte (s_tdata),
        .cfg     (cfg),
        .result  (core_result)
    );

    // hold results here until the master side takes them
    plfd_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (core_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {out_result.frame_len, out_result.payload_byte};
    assign m_tlast = out_result.frame_end;
    assign m_tuser = {out_result.payload_valid, out_result.phase_code};

endmodule

`default_nettype wire

### test/plfd_checker.sv
// Scoreboard for the preamble/length deframer: mirrors the register file from
// the APB port and checks reads against it, predicts one result per accepted
// byte and compares the results. Depends on plfd_pkg.
`timescale 1ns / 1ps

module plfd_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic [31:0] prdata,
    input  wire logic        pready,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,   // [7:0] payload_byte, [23:8] frame_len
    input  wire logic        m_tlast,   // frame_end
    input  wire logic [3:0]  m_tuser,   // [2:0] phase_code, [3] payload_valid
    output int               fail_count,
    output int               pending,
    output int               results_seen,
    output int               frames_seen,
    output int               rejects_seen
);

    // register mirror
    plfd_pkg::cfg_t      cfg;

    // deframer state copy
    plfd_pkg::phase_t    ph;
    logic [15:0]         cnt;
    logic [15:0]         plen;

    plfd_pkg::result_t   expected_q[$];
    int                  errs;
    int                  n_results;
    int                  n_frames;
    int                  n_rejects;

    task automatic advance_deframer(input logic [7:0] b, output plfd_pkg::result_t r);
        r = '0;
        case (ph)
            plfd_pkg::PH_IDLE: begin
                if (b == cfg.first_sync_byte) ph = plfd_pkg::PH_PREAMBLE;
            end
            plfd_pkg::PH_PREAMBLE: begin
                if (b == cfg.second_sync_byte) begin
                    cnt = 16'd0;
                    ph  = plfd_pkg::PH_LENGTH;
                end else begin
                    ph = plfd_pkg::PH_IDLE;
                end
            end
            plfd_pkg::PH_LENGTH: begin
                if (cnt == 16'd0) begin
                    plen[7:0] = b;
                    cnt       = 16'd1;
                end else begin
                    plen[15:8] = b;
                    if (plen > cfg.max_payload_len) begin
                        cnt = 16'd2;
                        ph  = plfd_pkg::PH_ERROR;
                    end else if (plen == 16'd0) begin
                        cnt = 16'd0;
                        ph  = plfd_pkg::PH_IDLE;
                    end else begin
                        cnt = 16'd0;
                        ph  = plfd_pkg::PH_COLLECT;
                    end
                end
            end
            plfd_pkg::PH_COLLECT: begin
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
                cnt             = cnt + 16'd1;
                if (cnt == plen) begin
                    ph          = plfd_pkg::PH_FOUND;
                    r.frame_end = 1'b1;
                    r.frame_len = plen;
                end
            end
            plfd_pkg::PH_FOUND: begin
                cnt = 16'd0;
                if (b == cfg.first_sync_byte) ph = plfd_pkg::PH_PREAMBLE;
            end
            default: begin
                // error (or an unreachable code): drop the byte, clear everything
                ph   = plfd_pkg::PH_IDLE;
                cnt  = 16'd0;
                plen = 16'd0;
            end
        endcase
        r.phase_code = ph;
    endtask

    always @(posedge aclk) begin
        plfd_pkg::result_t got;
        plfd_pkg::result_t want;
        plfd_pkg::result_t nxt;
        if (!aresetn) begin
            cfg.first_sync_byte  = plfd_pkg::FIRST_SYNC_RESET;
            cfg.second_sync_byte = plfd_pkg::SECOND_SYNC_RESET;
            cfg.max_payload_len  = plfd_pkg::MAX_LENGTH_RESET;
            ph        = plfd_pkg::PH_IDLE;
            cnt       = 16'd0;
            plen      = 16'd0;
            errs      = 0;
            n_results = 0;
            n_frames  = 0;
            n_rejects = 0;
            expected_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    plfd_pkg::REG_FIRST_SYNC:  cfg.first_sync_byte  = pwdata[7:0];
                    plfd_pkg::REG_SECOND_SYNC: cfg.second_sync_byte = pwdata[7:0];
                    plfd_pkg::REG_MAX_LENGTH:  cfg.max_payload_len  = pwdata[15:0];
                    default: ;
                endcase
            end

            if (psel && penable && !pwrite && pready) begin
                case (paddr[3:2])
                    plfd_pkg::REG_FIRST_SYNC: if (prdata[7:0] !== cfg.first_sync_byte) begin
                        $error("first_sync_byte read: expected %0h, got %0h",
                               cfg.first_sync_byte, prdata[7:0]);
                        errs++;
                    end
                    plfd_pkg::REG_SECOND_SYNC: if (prdata[7:0] !== cfg.second_sync_byte) begin
                        $error("second_sync_byte read: expected %0h, got %0h",
                               cfg.second_sync_byte, prdata[7:0]);
                        errs++;
                    end
                    plfd_pkg::REG_MAX_LENGTH: if (prdata[15:0] !== cfg.max_payload_len) begin
                        $error("max_payload_len read: expected %0d, got %0d",
                               cfg.max_payload_len, prdata[15:0]);
                        errs++;
                    end
                    default: ;
                endcase
            end

            // results first: a result leaving now belongs to an earlier byte
            if (m_tvalid && m_tready) begin
                got.phase_code    = m_tuser[2:0];
                got.payload_valid = m_tuser[3];
                got.payload_byte  = m_tdata[7:0];
                got.frame_end     = m_tlast;
                got.frame_len     = m_tdata[23:8];
                n_results++;
                if (expected_q.size() == 0) begin
                    $error("result with nothing expected: phase_code %0d", got.phase_code);
                    errs++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.phase_code !== want.phase_code) begin
                        $error("phase_code: expected %0d, got %0d",
                               want.phase_code, got.phase_code);
                        errs++;
                    end
                    if (got.payload_valid !== want.payload_valid) begin
                        $error("payload_valid: expected %0d, got %0d",
                               want.payload_valid, got.payload_valid);
                        errs++;
                    end
                    if (got.payload_byte !== want.payload_byte) begin
                        $error("payload_byte: expected %0h, got %0h",
                               want.payload_byte, got.payload_byte);
                        errs++;
                    end
                    if (got.frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0d, got %0d",
                               want.frame_end, got.frame_end);
                        errs++;
                    end
                    if (got.frame_len !== want.frame_len) begin
                        $error("frame_len: expected %0d, got %0d",
                               want.frame_len, got.frame_len);
                        errs++;
                    end
                    if (want.frame_end) n_frames++;
                    if (want.phase_code == plfd_pkg::PH_ERROR) n_rejects++;
                end
            end

            if (s_tvalid && s_tready) begin
                advance_deframer(s_tdata, nxt);
                expected_q.push_back(nxt);
            end
        end
        fail_count   <= errs;
        pending      <= expected_q.size();
        results_seen <= n_results;
        frames_seen  <= n_frames;
        rejects_seen <= n_rejects;
    end

endmodule

### test/tb_top.sv
// Testbench top for the preamble/length deframer: clock, reset, APB register
// writes and byte stimulus with bursty sending and a stalling receiver.
// Depends on plfd_pkg, preamble_length_deframer and plfd_checker.
`timescale 1ns / 1ps

module tb_top;

    // watchdog: far beyond the slowest legal run (gaps, stalls, a few long frames)
    localparam int CYCLE_LIMIT = 500000;
    // register address with no register behind it; writes must be ignored
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int N_SETTINGS = 6;
    localparam int BYTES_PER_SETTING = 215;

    typedef enum int {
        RX_OPEN,     // always ready
        RX_COIN,     // ready half the time
        RX_MOSTLY,   // ready three times in four
        RX_BLOCK     // held off for the whole stretch
    } rx_mode_t;

    typedef struct {
        logic [31:0] first;
        logic [31:0] second;
        logic [31:0] maxlen;
    } setting_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic [3:0]  m_tuser;

    int fail_count;
    int pending;
    int results_seen;
    int frames_seen;
    int rejects_seen;

    // stimulus-side copy of the registers, used only to shape the traffic
    logic [7:0]  first_sync;
    logic [7:0]  second_sync;
    logic [15:0] max_len;

    int       bytes_sent = 0;
    int       burst_left = 0;
    int       cycles     = 0;
    rx_mode_t rx_mode    = RX_OPEN;
    int       rx_left    = 0;

    preamble_length_deframer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    plfd_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .frames_seen  (frames_seen),
        .rejects_seen (rejects_seen)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Receiver: pick a stall mode for a stretch of random length, then another.
    // Blocked stretches are kept short so the sender sees back-pressure without
    // the run crawling.
    always @(posedge aclk) begin
        if (rx_left <= 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = (rx_mode == RX_BLOCK) ? $urandom_range(1, 12) : $urandom_range(5, 60);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
            RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
            default:   m_tready <= 1'b0;
        endcase
    end

    // Offer one byte and hold it until the transaction completes. Between
    // bursts drop tvalid for a random gap; now and then run a long burst with
    // no gaps at all.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(100, 300);
            else burst_left = $urandom_range(1, 30);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        burst_left--;
        bytes_sent++;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Preamble plus a little-endian length; the payload is up to the caller.
    task automatic send_header(input logic [15:0] len);
        send_byte(first_sync);
        send_byte(second_sync);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
    endtask

    task automatic send_frame(input logic [15:0] len);
        send_header(len);
        for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
    endtask

    // Drop tvalid, wait for every outstanding result, then let the pipeline
    // drain so the block is idle before the registers change.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [1:0] idx);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Program all three registers (upper pwdata bits may carry junk that the
    // block must drop), poke the unused address, and read the three registers back.
    task automatic apply_setting(input setting_t s);
        apb_write(plfd_pkg::REG_FIRST_SYNC, s.first);
        apb_write(plfd_pkg::REG_SECOND_SYNC, s.second);
        apb_write(plfd_pkg::REG_MAX_LENGTH, s.maxlen);
        apb_write(REG_UNUSED, $urandom);
        first_sync  = s.first[7:0];
        second_sync = s.second[7:0];
        max_len     = s.maxlen[15:0];
        apb_read(plfd_pkg::REG_FIRST_SYNC);
        apb_read(plfd_pkg::REG_SECOND_SYNC);
        apb_read(plfd_pkg::REG_MAX_LENGTH);
    endtask

    // Mostly well-formed frames with random payload if the maximum allows; the
    // rest is zero lengths, oversize lengths, broken preambles and line noise.
    task automatic run_traffic(input int budget);
        int start;
        int pick;
        int cap;
        int len;
        int n;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            pick = $urandom_range(0, 99);
            cap  = (max_len < 24) ? int'(max_len) : 24;
            if (pick < 65 && cap > 0) begin
                len = $urandom_range(1, cap);
                // a rare long frame exercises the upper length byte
                if (max_len >= 300 && $urandom_range(0, 59) == 0) len = 300;
                send_frame(16'(len));
            end else if (pick < 72) begin
                send_header(16'd0);
            end else if (pick < 82 && max_len != 16'hFFFF) begin
                // oversize: the byte after the length is swallowed, so pad it
                send_header(16'($urandom_range(int'(max_len) + 1, 65535)));
                send_byte(8'($urandom_range(0, 255)));
            end else if (pick < 90) begin
                // broken preamble: wrong byte straight after the first sync byte
                send_byte(first_sync);
                send_byte(second_sync ^ 8'($urandom_range(1, 255)));
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        setting_t plan [N_SETTINGS];

        plan[0] = '{32'h0000_00FC, 32'h0000_00CC, 32'd4096};    // reset values again
        plan[1] = '{32'h0000_0000, 32'h0000_00FF, 32'd1};       // smallest nonzero maximum
        plan[2] = '{32'hFFFF_FFFF, 32'hABCD_EF00, 32'hFFFF_FFFF}; // all-ones, junk bits
        plan[3] = '{32'h0000_00A5, 32'h0000_00A5, 32'd0};       // zero maximum, equal syncs
        plan[4] = '{$urandom, $urandom, 32'd8};
        plan[5] = '{$urandom, $urandom, $urandom};

        first_sync  = plfd_pkg::FIRST_SYNC_RESET;
        second_sync = plfd_pkg::SECOND_SYNC_RESET;
        max_len     = plfd_pkg::MAX_LENGTH_RESET;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // check the reset values of the registers
        apb_read(plfd_pkg::REG_FIRST_SYNC);
        apb_read(plfd_pkg::REG_SECOND_SYNC);
        apb_read(plfd_pkg::REG_MAX_LENGTH);

        // directed: shortest frame, one random payload byte
        send_frame(16'd1);
        // a non-sync byte in found stays in found
        send_byte(8'h33);
        // back-to-back frame straight from found, payload bytes FF and 55
        send_header(16'd2);
        send_byte(8'hFF);
        send_byte(8'h55);
        // zero length goes back to idle
        send_header(16'd0);
        // one above the maximum: error, and the next byte (a first sync) is dropped
        send_header(plfd_pkg::MAX_LENGTH_RESET + 16'd1);
        send_byte(first_sync);
        // wrong second byte equal to the first sync byte is not taken as a new start
        send_byte(first_sync);
        send_byte(first_sync);
        send_byte(second_sync);
        settle();

        for (int k = 0; k < N_SETTINGS; k++) begin
            apply_setting(plan[k]);
            run_traffic(BYTES_PER_SETTING);
            settle();
        end

        repeat (20) @(posedge aclk);

        $display("tb_top: %0d bytes sent over %0d register settings, %0d results checked",
                 bytes_sent, N_SETTINGS + 1, results_seen);
        $display("tb_top: %0d complete frames, %0d oversize lengths rejected",
                 frames_seen, rejects_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
